### sv/mdio_management_slave_phy_assert.svh
// assertion macros used by the checker file
`ifndef MDIO_MANAGEMENT_SLAVE_PHY_ASSERT_SVH
`define MDIO_MANAGEMENT_SLAVE_PHY_ASSERT_SVH

// condition must hold in the same cycle
`define MMS_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("mdio slave check failed");

// condition must hold in the next cycle
`define MMS_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("mdio slave check failed");

`endif

### sv/mms_pkg.sv
`default_nettype none
package mms_pkg;

   localparam int PHASE_W = 3;
   localparam int COUNT_W = 7;
   localparam int ADDR_W  = 5;
   localparam int DATA_W  = 16;
   localparam int NUM_REGS = 32;

   localparam int PREAMBLE_BITS_DEFAULT = 32;
   localparam logic [ADDR_W-1:0] PHY_ADDRESS_RESET = 5'd1;

   // frame phases
   localparam logic [PHASE_W-1:0] PH_PREAMBLE = 3'd0;
   localparam logic [PHASE_W-1:0] PH_START    = 3'd1;
   localparam logic [PHASE_W-1:0] PH_OPCODE   = 3'd2;
   localparam logic [PHASE_W-1:0] PH_ADDRESS  = 3'd3;
   localparam logic [PHASE_W-1:0] PH_REGISTER = 3'd4;
   localparam logic [PHASE_W-1:0] PH_TURN     = 3'd5;
   localparam logic [PHASE_W-1:0] PH_DATA     = 3'd6;

   localparam logic [1:0] OP_READ = 2'd2;

   // phy register numbers
   localparam logic [ADDR_W-1:0] REG_CONTROL   = 5'd0;
   localparam logic [ADDR_W-1:0] REG_STATUS    = 5'd1;
   localparam logic [ADDR_W-1:0] REG_ID1       = 5'd2;
   localparam logic [ADDR_W-1:0] REG_ID2       = 5'd3;
   localparam logic [ADDR_W-1:0] REG_ADVERTISE = 5'd4;
   localparam logic [ADDR_W-1:0] REG_PARTNER   = 5'd5;
   localparam logic [ADDR_W-1:0] REG_SPEED     = 5'd18;

   typedef struct packed {
      logic mdc_level;
      logic mdio_set;
      logic mdio_value;
   } req_type;

   typedef struct packed {
      logic [PHASE_W-1:0] frame_phase;
      logic               mdio_line;
   } rsp_type;

   typedef struct packed {
      logic              we;
      logic [ADDR_W-1:0] addr;
      logic [DATA_W-1:0] data;
   } regwr_type;

endpackage
`default_nettype wire

### sv/mdio_management_slave_phy.sv
// MDIO clause 22 management slave with a 32 x 16 PHY register file. Each request is one
// write of the management lines (new MDC level, optional new MDIO level); every request
// gives exactly one response with the MDIO line level and the frame phase after it.
// One request is taken every clock cycle while the output queue has room: the frame machine's
// state registers feed a single combinational pass, and each response is registered into a
// two-entry output queue, so requests keep flowing while one response waits. The user must
// write the PHY address register through the csr port only while the block is idle (unenforced).
`default_nettype none
module mdio_management_slave_phy #(
   parameter int PREAMBLE_BITS = mms_pkg::PREAMBLE_BITS_DEFAULT
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // bit 0 mdio_value, bit 1 mdio_set, bit 2 mdc_level, bits 7:3 zero
   input  wire logic [7:0]  req_tdata,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // bit 0 mdio_line, bits 3:1 frame_phase, bits 7:4 zero
   output logic      [7:0]  rsp_tdata,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   input  wire logic [mms_pkg::ADDR_W-1:0] csr_data,
   input  wire logic        csr_valid,
   output logic             csr_ready
);

   logic [mms_pkg::ADDR_W-1:0] phy_address_ff;
   logic                       req_fire;
   mms_pkg::req_type           req;
   mms_pkg::rsp_type           rsp_next;
   mms_pkg::rsp_type           rsp_out;
   mms_pkg::regwr_type         wr;
   logic [mms_pkg::ADDR_W-1:0] rd_addr;
   logic [mms_pkg::DATA_W-1:0] rd_data;

   assign csr_ready = 1'b1;
   assign req_fire  = req_tvalid && req_tready;
   assign req       = '{mdc_level: req_tdata[2], mdio_set: req_tdata[1],
                        mdio_value: req_tdata[0]};
   assign rsp_tdata = {4'b0000, rsp_out.frame_phase, rsp_out.mdio_line};

   always_ff @(posedge clock) begin
      if (reset) begin
         phy_address_ff <= mms_pkg::PHY_ADDRESS_RESET;
      end else if (csr_valid && csr_ready) begin
         phy_address_ff <= csr_data;
      end
   end

   mms_frame #(
      .PREAMBLE_BITS (PREAMBLE_BITS)
   ) u_frame (
      .clock       (clock),
      .reset       (reset),
      .req_fire    (req_fire),
      .req         (req),
      .phy_address (phy_address_ff),
      .rd_data     (rd_data),
      .rd_addr     (rd_addr),
      .wr          (wr),
      .rsp         (rsp_next)
   );

   mms_regfile u_regfile (
      .clock   (clock),
      .reset   (reset),
      .wr      (wr),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   mms_rsp_buf u_rsp_buf (
      .clock     (clock),
      .reset     (reset),
      .push      (req_fire),
      .push_data (rsp_next),
      .can_push  (req_tready),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp_data  (rsp_out)
   );

endmodule
`default_nettype wire

### sv/mms_regfile.sv
`default_nettype none
module mms_regfile (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire mms_pkg::regwr_type          wr,
   input  wire logic [mms_pkg::ADDR_W-1:0]  rd_addr,
   output logic      [mms_pkg::DATA_W-1:0]  rd_data
);

   localparam logic [mms_pkg::DATA_W-1:0] STATUS_VALUE  = 16'h782c;
   localparam logic [mms_pkg::DATA_W-1:0] PARTNER_BASE  = 16'h4001;
   localparam logic [mms_pkg::DATA_W-1:0] PARTNER_MASK  = 16'h01e0;

   logic [mms_pkg::DATA_W-1:0] regs_ff [mms_pkg::NUM_REGS];
   logic [mms_pkg::DATA_W-1:0] adv;
   logic                       fast_mode;
   logic                       full_duplex;

   function automatic logic [mms_pkg::DATA_W-1:0] reset_word(
      input logic [mms_pkg::ADDR_W-1:0] idx
   );
      unique case (idx)
         mms_pkg::REG_CONTROL:   reset_word = 16'h3100;
         mms_pkg::REG_ID1:       reset_word = 16'h0300;
         mms_pkg::REG_ID2:       reset_word = 16'he400;
         mms_pkg::REG_ADVERTISE: reset_word = 16'h01e1;
         default:                reset_word = '0;
      endcase
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < mms_pkg::NUM_REGS; i++) begin
            regs_ff[i] <= reset_word(mms_pkg::ADDR_W'(i));
         end
      end else if (wr.we) begin
         regs_ff[wr.addr] <= wr.data;
      end
   end

   assign adv         = regs_ff[mms_pkg::REG_ADVERTISE];
   // 100 Mb/s half or full, and any full-duplex mode
   assign fast_mode   = adv[8] | adv[7];
   assign full_duplex = adv[8] | adv[6];

   always_comb begin
      unique case (rd_addr)
         mms_pkg::REG_STATUS:  rd_data = STATUS_VALUE;
         mms_pkg::REG_PARTNER: rd_data = PARTNER_BASE | (adv & PARTNER_MASK);
         mms_pkg::REG_SPEED:   rd_data = {4'b0000, full_duplex, fast_mode, 10'b0};
         default:              rd_data = regs_ff[rd_addr];
      endcase
   end

endmodule
`default_nettype wire

### sv/mms_frame.sv
`default_nettype none
module mms_frame #(
   parameter int PREAMBLE_BITS = mms_pkg::PREAMBLE_BITS_DEFAULT
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_fire,
   input  wire mms_pkg::req_type            req,
   input  wire logic [mms_pkg::ADDR_W-1:0]  phy_address,
   input  wire logic [mms_pkg::DATA_W-1:0]  rd_data,
   output logic      [mms_pkg::ADDR_W-1:0]  rd_addr,
   output mms_pkg::regwr_type               wr,
   output mms_pkg::rsp_type                 rsp
);

   localparam int CW = mms_pkg::COUNT_W;
   localparam logic [CW-1:0] PREAMBLE_EDGES = CW'(PREAMBLE_BITS * 2);
   localparam logic [CW-1:0] START_EDGES    = CW'(2);
   localparam logic [CW-1:0] OPCODE_EDGES   = CW'(2 * 2);
   localparam logic [CW-1:0] FIELD_EDGES    = CW'(5 * 2);
   localparam logic [CW-1:0] TURN_EDGES     = CW'(2 * 2);
   localparam logic [CW-1:0] DATA_EDGES     = CW'(16 * 2);
   localparam logic [CW-1:0] COUNT_MAX      = {CW{1'b1}};

   logic [mms_pkg::PHASE_W-1:0] phase_ff, phase_in;
   logic [CW-1:0]               count_ff, count_in;
   logic [1:0]                  opcode_ff, opcode_in;
   logic [mms_pkg::ADDR_W-1:0]  addr_ff, addr_in;
   logic [mms_pkg::ADDR_W-1:0]  regnum_ff, regnum_in;
   logic [mms_pkg::DATA_W-1:0]  shift_ff, shift_in;
   logic                        driving_ff, driving_in;
   logic                        clock_ff, clock_in;
   logic                        line_ff, line_in;

   logic                        line_now;
   logic                        fall;
   logic [CW-1:0]               count_inc;
   logic                        addr_match;
   logic [mms_pkg::DATA_W-1:0]  read_word;
   logic [mms_pkg::DATA_W-1:0]  shift_rx;

   assign rd_addr    = regnum_ff;
   assign line_now   = req.mdio_set ? req.mdio_value : line_ff;
   assign fall       = clock_ff;
   assign count_inc  = (count_ff != COUNT_MAX) ? count_ff + 1'b1 : count_ff;
   assign addr_match = (addr_ff == phy_address);
   assign read_word  = addr_match ? rd_data : '1;
   assign shift_rx   = driving_ff ? shift_ff : {shift_ff[mms_pkg::DATA_W-2:0], line_now};

   always_comb begin
      phase_in   = phase_ff;
      count_in   = count_ff;
      opcode_in  = opcode_ff;
      addr_in    = addr_ff;
      regnum_in  = regnum_ff;
      shift_in   = shift_ff;
      driving_in = driving_ff;
      clock_in   = req.mdc_level;
      line_in    = line_now;
      wr         = '{we: 1'b0, addr: regnum_ff, data: shift_rx};

      if (req.mdc_level != clock_ff) begin
         count_in = count_inc;
         unique case (phase_ff)
            mms_pkg::PH_PREAMBLE: begin
               if (fall && count_inc >= PREAMBLE_EDGES && !line_now) begin
                  count_in = '0;
                  phase_in = mms_pkg::PH_START;
                  shift_in = '0;
               end
            end
            mms_pkg::PH_START: begin
               if (fall && count_inc == START_EDGES) begin
                  count_in  = '0;
                  opcode_in = '0;
                  phase_in  = mms_pkg::PH_OPCODE;
               end
            end
            mms_pkg::PH_OPCODE: begin
               if (fall) begin
                  opcode_in = {opcode_ff[0], line_now};
                  if (count_inc == OPCODE_EDGES) begin
                     count_in = '0;
                     addr_in  = '0;
                     phase_in = mms_pkg::PH_ADDRESS;
                  end
               end
            end
            mms_pkg::PH_ADDRESS: begin
               if (fall) begin
                  addr_in = {addr_ff[mms_pkg::ADDR_W-2:0], line_now};
                  if (count_inc == FIELD_EDGES) begin
                     count_in  = '0;
                     regnum_in = '0;
                     phase_in  = mms_pkg::PH_REGISTER;
                  end
               end
            end
            mms_pkg::PH_REGISTER: begin
               if (fall) begin
                  regnum_in = {regnum_ff[mms_pkg::ADDR_W-2:0], line_now};
                  if (count_inc == FIELD_EDGES) begin
                     count_in = '0;
                     phase_in = mms_pkg::PH_TURN;
                  end
               end
            end
            mms_pkg::PH_TURN: begin
               if (fall && count_inc == TURN_EDGES) begin
                  count_in = '0;
                  line_in  = 1'b0;
                  phase_in = mms_pkg::PH_DATA;
                  if (opcode_ff == mms_pkg::OP_READ) begin
                     // lsb goes out first, then msb-first shifting on rising edges
                     driving_in = 1'b1;
                     shift_in   = read_word;
                     line_in    = read_word[0];
                  end
               end
            end
            mms_pkg::PH_DATA: begin
               if (!fall) begin
                  if (driving_ff) begin
                     line_in  = shift_ff[mms_pkg::DATA_W-1];
                     shift_in = {shift_ff[mms_pkg::DATA_W-2:0], 1'b0};
                  end
               end else begin
                  shift_in = shift_rx;
                  if (count_inc == DATA_EDGES) begin
                     count_in   = '0;
                     phase_in   = mms_pkg::PH_PREAMBLE;
                     driving_in = 1'b0;
                     wr.we      = req_fire && !driving_ff && addr_match;
                  end
               end
            end
            default: begin
               phase_in = mms_pkg::PH_PREAMBLE;
            end
         endcase
      end

      rsp.mdio_line   = line_in;
      rsp.frame_phase = phase_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= mms_pkg::PH_PREAMBLE;
         count_ff   <= '0;
         opcode_ff  <= '0;
         addr_ff    <= '0;
         regnum_ff  <= '0;
         shift_ff   <= '0;
         driving_ff <= 1'b0;
         clock_ff   <= 1'b0;
         line_ff    <= 1'b0;
      end else if (req_fire) begin
         phase_ff   <= phase_in;
         count_ff   <= count_in;
         opcode_ff  <= opcode_in;
         addr_ff    <= addr_in;
         regnum_ff  <= regnum_in;
         shift_ff   <= shift_in;
         driving_ff <= driving_in;
         clock_ff   <= clock_in;
         line_ff    <= line_in;
      end
   end

endmodule
`default_nettype wire

### sv/mms_rsp_buf.sv
`default_nettype none
module mms_rsp_buf (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire mms_pkg::rsp_type push_data,
   output logic                  can_push,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output mms_pkg::rsp_type      rsp_data
);

   // two-entry queue: head register plus skid register
   mms_pkg::rsp_type head_ff, head_in;
   mms_pkg::rsp_type skid_ff, skid_in;
   logic [1:0]       count_ff, count_in;
   logic             pop;

   assign rsp_valid = (count_ff != 2'd0);
   assign can_push  = (count_ff != 2'd2);
   assign rsp_data  = head_ff;
   assign pop       = rsp_valid && rsp_ready;

   always_comb begin
      head_in  = head_ff;
      skid_in  = skid_ff;
      count_in = count_ff;
      if (pop) begin
         head_in = skid_ff;
      end
      if (push) begin
         if (count_ff == 2'd0 || (pop && count_ff == 2'd1)) begin
            head_in = push_data;
         end else begin
            skid_in = push_data;
         end
      end
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      head_ff <= head_in;
      skid_ff <= skid_in;
   end

endmodule
`default_nettype wire

### sv/mms_checker.sv
`default_nettype none
`include "mdio_management_slave_phy_assert.svh"
module mms_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_tvalid,
   input wire logic       req_tready,
   input wire logic [7:0] rsp_tdata,
   input wire logic       rsp_tvalid,
   input wire logic       rsp_tready
);

   // every accepted request leaves a response waiting in the next cycle
   `MMS_ASSERT_NEXT(a_request_gives_response, req_tvalid && req_tready, rsp_tvalid)
   // an empty response queue never backpressures requests
   `MMS_ASSERT_SAME(a_ready_when_empty, !rsp_tvalid, req_tready)
   // a stalled response holds
   `MMS_ASSERT_NEXT(a_stalled_response_holds, rsp_tvalid && !rsp_tready,
      rsp_tvalid && $stable(rsp_tdata))

endmodule

bind mdio_management_slave_phy mms_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready)
);
`default_nettype wire
